### src/frt_pkg.sv
package frt_pkg;

  localparam int SLOTS          = 32;
  localparam int SLOT_W         = 5;
  localparam int MAX_FRAGS      = 256;
  localparam int FRAG_W         = 8;
  localparam int MAX_DATAGRAM   = 8192;
  localparam int LEN_W          = 13;
  localparam int FRAG_HDR_BYTES = 14;
  localparam int MSG_HDR_BYTES  = 23;
  localparam int PREFIX_BYTES   = 4;
  localparam int START_BYTE_POS = MSG_HDR_BYTES + 4;
  localparam int FBYTES_W       = 22;
  localparam logic [FBYTES_W-1:0] FRAME_BYTES_MAX = '1;

  localparam logic [2:0] STAT_STORED = 3'd0;
  localparam logic [2:0] STAT_DONE   = 3'd1;
  localparam logic [2:0] STAT_STALE  = 3'd2;
  localparam logic [2:0] STAT_WAIT   = 3'd3;
  localparam logic [2:0] STAT_SHORT  = 3'd4;
  localparam logic [2:0] STAT_FULL   = 3'd5;

  localparam logic [7:0] REG_REORDER_WINDOW = 8'd0;
  localparam logic [7:0] REG_START_TYPE     = 8'd1;

  typedef struct packed {
    logic [13:0] packet_bytes;
    logic [15:0] message_id;
    logic [7:0]  fragment_count;
    logic [7:0]  fragment_index;
    logic [7:0]  start_type_byte;
    logic [31:0] frame_length_field;
  } hdr_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [15:0]         result_message_id;
    logic [SLOT_W-1:0]   slot_index;
    logic [FBYTES_W-1:0] frame_bytes;
    logic [31:0]         frame_length;
    logic                buffer_half;
    logic [5:0]          evicted_count;
  } res_t;

  typedef struct packed {
    logic [15:0] message_id;
    logic [7:0]  expected_count;
    logic [8:0]  received_count;
    logic [7:0]  start_byte;
    logic [31:0] frame_length;
  } slot_entry_t;

  typedef struct packed {
    logic             seen;
    logic [LEN_W-1:0] len;
  } frag_entry_t;

endpackage

### src/frt_ram.sv
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/fragment_reassembly_tracker_unit.sv
// channel | signals                                   | role
// hdr     | hdr_valid, hdr_ready, hdr (hdr_t)         | one fragment header per item
// res     | res_valid, res_ready, res (res_t)         | one result per header
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// a header is taken in idle; then come a slot search over the slot ram, a clear of the
// slot's fragment entries when a new message gets a slot, a read and update of its fragment
// entry and a load of the result register; a header shorter than the fragment header
// goes straight to the result register. a completion adds a read of fragment 0, a sum
// over the other fragments and an eviction sweep over the slot ram
// fragment ram (8192 x 14) needs no clearing pass: a slot's region is cleared on allocation
// rst is synchronous; the result register holds a result while res_ready is low and the
// next header is still taken
module fragment_reassembly_tracker_unit
  import frt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        hdr_valid,
  output logic        hdr_ready,
  input  hdr_t        hdr,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRCH  = 4'd1;
  localparam logic [3:0] ST_CLR   = 4'd2;
  localparam logic [3:0] ST_FRD   = 4'd3;
  localparam logic [3:0] ST_UPD   = 4'd4;
  localparam logic [3:0] ST_L0RD  = 4'd5;
  localparam logic [3:0] ST_LEN0  = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_EVICT = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]          state;
  logic [15:0]         reorder_window;
  logic [7:0]          start_type;
  logic [SLOTS-1:0]    slot_valid;
  logic [15:0]         last_decoded_id;
  logic                awaiting_start;
  logic                buffer_select;

  hdr_t                hq;
  logic [13:0]         pb;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   free_slot;
  logic                have_free;
  logic [SLOT_W:0]     sw_idx;
  logic                pend;
  logic [8:0]          frag_cnt;
  slot_entry_t         ent;
  res_t                rbuf;
  res_t                rbuf_start;

  logic                slot_we;
  slot_entry_t         slot_wdata;
  slot_entry_t         slot_rdata;
  logic                frag_we;
  logic [SLOT_W+FRAG_W-1:0] frag_waddr;
  logic [SLOT_W+FRAG_W-1:0] frag_raddr;
  frag_entry_t         frag_wdata;
  frag_entry_t         frag_rdata;

  logic [SLOT_W-1:0]   prev;
  logic [LEN_W-1:0]    len;
  logic [8:0]          rcv_next;
  slot_entry_t         ent_next;
  logic [LEN_W-1:0]    len0;
  logic [15:0]         id_gap;
  logic [15:0]         evd;
  logic [FBYTES_W:0]   sum_next;

  assign hdr_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign prev = SLOT_W'(sw_idx - 1'b1);
  assign len  = LEN_W'(pb - 14'(FRAG_HDR_BYTES));
  assign id_gap = last_decoded_id - hq.message_id;
  assign evd  = last_decoded_id - slot_rdata.message_id;
  assign len0 = frag_rdata.seen ? frag_rdata.len : '0;
  assign sum_next = {1'b0, rbuf.frame_bytes} + (FBYTES_W+1)'(frag_rdata.len);

  always_comb begin
    rbuf_start                   = '0;
    rbuf_start.result_message_id = hdr.message_id;
    rbuf_start.status            = (hdr.packet_bytes < 14'(FRAG_HDR_BYTES)) ?
                                   STAT_SHORT : STAT_STORED;
  end

  always_comb begin
    rcv_next = ent.received_count + (frag_rdata.seen ? 9'd0 : 9'd1);
    ent_next = ent;
    ent_next.expected_count = hq.fragment_count;
    ent_next.received_count = rcv_next;
    if (hq.fragment_index == '0) begin
      ent_next.start_byte   = hq.start_type_byte;
      ent_next.frame_length = hq.frame_length_field;
    end
  end

  assign slot_we    = (state == ST_UPD);
  assign slot_wdata = ent_next;

  always_comb begin
    frag_we    = 1'b0;
    frag_waddr = {slot, hq.fragment_index};
    frag_wdata = '0;
    frag_raddr = {slot, hq.fragment_index};
    case (state)
      ST_CLR: begin
        frag_we    = 1'b1;
        frag_waddr = {slot, frag_cnt[FRAG_W-1:0]};
      end
      ST_UPD: begin
        frag_we    = 1'b1;
        frag_wdata = '{seen: 1'b1, len: len};
      end
      ST_L0RD: frag_raddr = {slot, {FRAG_W{1'b0}}};
      ST_SUM:  frag_raddr = {slot, frag_cnt[FRAG_W-1:0]};
      default: ;
    endcase
  end

  frt_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot),
    .wdata (slot_wdata),
    .raddr (sw_idx[SLOT_W-1:0]),
    .rdata (slot_rdata)
  );

  frt_ram #(.WIDTH($bits(frag_entry_t)), .DEPTH(SLOTS * MAX_FRAGS)) u_frag_ram (
    .clk   (clk),
    .we    (frag_we),
    .waddr (frag_waddr),
    .wdata (frag_wdata),
    .raddr (frag_raddr),
    .rdata (frag_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      reorder_window  <= 16'd30;
      start_type      <= 8'h67;
      slot_valid      <= '0;
      last_decoded_id <= '0;
      awaiting_start  <= 1'b1;
      buffer_select   <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_REORDER_WINDOW) begin
          reorder_window <= cfg_data;
        end else if (cfg_index == REG_START_TYPE) begin
          start_type <= cfg_data[7:0];
        end
      end
      if (res_valid && res_ready && state != ST_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (hdr_valid) begin
            hq        <= hdr;
            pb        <= (hdr.packet_bytes > 14'(MAX_DATAGRAM)) ?
                         14'(MAX_DATAGRAM) : hdr.packet_bytes;
            rbuf      <= rbuf_start;
            sw_idx    <= '0;
            pend      <= 1'b0;
            have_free <= 1'b0;
            if (hdr.packet_bytes < 14'(FRAG_HDR_BYTES)) begin
              state <= ST_OUT;
            end else begin
              state <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (pend && slot_valid[prev] && slot_rdata.message_id == hq.message_id) begin
            slot  <= prev;
            ent   <= slot_rdata;
            state <= ST_FRD;
          end else begin
            if (pend && !slot_valid[prev] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= prev;
            end
            if (sw_idx < (SLOT_W+1)'(SLOTS)) begin
              sw_idx <= sw_idx + 1'b1;
              pend   <= 1'b1;
            end else begin
              pend <= 1'b0;
              if (!pend) begin
                if (have_free) begin
                  slot                   <= free_slot;
                  ent.message_id         <= hq.message_id;
                  ent.received_count     <= '0;
                  frag_cnt               <= '0;
                  state                  <= ST_CLR;
                end else begin
                  rbuf.status <= STAT_FULL;
                  state       <= ST_OUT;
                end
              end
            end
          end
        end
        ST_CLR: begin
          if (frag_cnt == 9'(MAX_FRAGS - 1)) begin
            state <= ST_FRD;
          end else begin
            frag_cnt <= frag_cnt + 1'b1;
          end
        end
        ST_FRD: state <= ST_UPD;
        ST_UPD: begin
          ent              <= ent_next;
          rbuf.slot_index  <= slot;
          if (rcv_next != {1'b0, hq.fragment_count}) begin
            slot_valid[slot] <= 1'b1;
            rbuf.status      <= STAT_STORED;
            state            <= ST_OUT;
          end else if (last_decoded_id > hq.message_id && id_gap < reorder_window) begin
            slot_valid[slot] <= 1'b0;
            rbuf.status      <= STAT_STALE;
            state            <= ST_OUT;
          end else begin
            slot_valid[slot] <= 1'b1;
            state            <= ST_L0RD;
          end
        end
        ST_L0RD: state <= ST_LEN0;
        ST_LEN0: begin
          if (awaiting_start && len0 <= LEN_W'(START_BYTE_POS)) begin
            rbuf.status <= STAT_SHORT;
            state       <= ST_OUT;
          end else if (awaiting_start && ent.start_byte != start_type) begin
            rbuf.status <= STAT_WAIT;
            state       <= ST_OUT;
          end else begin
            awaiting_start   <= 1'b0;
            last_decoded_id  <= hq.message_id;
            rbuf.frame_bytes <= FBYTES_W'(PREFIX_BYTES) +
                                ((len0 > LEN_W'(MSG_HDR_BYTES)) ?
                                 FBYTES_W'(len0 - LEN_W'(MSG_HDR_BYTES)) : '0);
            rbuf.frame_length <= frag_rdata.seen ? ent.frame_length : '0;
            rbuf.buffer_half  <= buffer_select;
            buffer_select     <= ~buffer_select;
            slot_valid[slot]  <= 1'b0;
            frag_cnt          <= 9'd1;
            pend              <= 1'b0;
            state             <= ST_SUM;
          end
        end
        ST_SUM: begin
          // fragments 1 .. count-1, one read per cycle
          if (pend && frag_rdata.seen) begin
            rbuf.frame_bytes <= (sum_next > {1'b0, FRAME_BYTES_MAX}) ?
                                FRAME_BYTES_MAX : sum_next[FBYTES_W-1:0];
          end
          if (frag_cnt < {1'b0, hq.fragment_count}) begin
            frag_cnt <= frag_cnt + 1'b1;
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              sw_idx <= '0;
              state  <= ST_EVICT;
            end
          end
        end
        ST_EVICT: begin
          if (pend && slot_valid[prev] && last_decoded_id > slot_rdata.message_id &&
              evd > reorder_window) begin
            slot_valid[prev]   <= 1'b0;
            rbuf.evicted_count <= rbuf.evicted_count + 1'b1;
          end
          if (sw_idx < (SLOT_W+1)'(SLOTS)) begin
            sw_idx <= sw_idx + 1'b1;
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              rbuf.status <= STAT_DONE;
              state       <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            res       <= rbuf;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> state == ST_IDLE && !res_valid)
    else $error("not idle after reset");

  a_sum_after_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> !awaiting_start)
    else $error("frame summed before start frame");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status <= STAT_FULL)
    else $error("bad status code");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != STAT_DONE |->
      res.frame_bytes == '0 && res.evicted_count == '0 && !res.buffer_half)
    else $error("completion fields set without completion");

endmodule
